FILE: sv/sidau_pkg.sv
// ----------------------------------------------------------------------------
// sidau_pkg: shared types and constants for the decimal ascii converter
// Character codes, bcd digit constants and the digit count helper.
// ----------------------------------------------------------------------------
package sidau_pkg;

  typedef logic [6:0] char_t;
  typedef logic [3:0] digit_t;

  localparam int DIGIT_W    = 4;
  localparam int VALUE_IN_W = 32;

  localparam char_t  CHR_MINUS  = 7'd45;
  localparam char_t  CHR_ZERO   = 7'd48;
  localparam digit_t ADJ_THRESH = 4'd5;
  localparam digit_t ADJ_ADD    = 4'd3;

  // number of decimal digits of the largest magnitude, 2^(w-1)
  function automatic int dec_digits(input int w);
    logic [67:0] lim;
    logic [67:0] p;
    int          n;
    lim = 68'd1 << (w - 1);
    p   = 68'd10;
    n   = 1;
    for (int i = 0; i < 20; i++) begin
      if (p <= lim) begin
        p = p * 68'd10;
        n = n + 1;
      end
    end
    return n;
  endfunction

endpackage

FILE: sv/sidau_bcd_adjust.sv
// ----------------------------------------------------------------------------
// sidau_bcd_adjust: add-three correction for one shift-add step
// Every bcd digit of five or more gets three added before the next shift.
// ----------------------------------------------------------------------------
module sidau_bcd_adjust
  import sidau_pkg::*;
#(
  parameter int NUM_DIGITS = 10
) (
  input  logic [NUM_DIGITS*DIGIT_W-1:0] bcd_i,
  output logic [NUM_DIGITS*DIGIT_W-1:0] bcd_o
);

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_i[i*DIGIT_W +: DIGIT_W] >= ADJ_THRESH) begin
        bcd_o[i*DIGIT_W +: DIGIT_W] = bcd_i[i*DIGIT_W +: DIGIT_W] + ADJ_ADD;
      end else begin
        bcd_o[i*DIGIT_W +: DIGIT_W] = bcd_i[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

endmodule

FILE: sv/signed_int_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit: signed integer to decimal ascii text
// Sequence: serial bcd shift-add over all magnitude bits, an alignment step,
// then one character per cycle while out_stall is low ('-' first when
// negative), most significant first. A new value is accepted only in idle;
// in_stall stays high until the last character has been issued.
// Reset: synchronous active-low rst_n clears the sequencer and output valid.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit
  import sidau_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VALUE_IN_W-1:0] in_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [6:0]            out_ascii_char,
  output logic                  out_last_char
);

  localparam int ND     = dec_digits(VALUE_WIDTH);
  localparam int BCD_W  = ND * DIGIT_W;
  localparam int CNT_W  = $clog2(VALUE_WIDTH + 1);
  localparam int NDIG_W = $clog2(ND + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CONV  = 3'd1;
  localparam logic [2:0] S_ALIGN = 3'd2;
  localparam logic [2:0] S_SIGN  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]             state_r, state_nxt;
  logic [VALUE_WIDTH-1:0] mag_r, mag_nxt;
  logic                   neg_r, neg_nxt;
  logic [BCD_W-1:0]       bcd_r, bcd_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [NDIG_W-1:0]      ndig_r, ndig_nxt;
  logic                   out_valid_r, out_valid_nxt;
  char_t                  out_char_r, out_char_nxt;
  logic                   out_last_r, out_last_nxt;

  logic [VALUE_WIDTH-1:0] val;
  logic                   val_neg;
  logic [VALUE_WIDTH-1:0] val_mag;
  logic [BCD_W-1:0]       bcd_adj;
  logic [NDIG_W-1:0]      lz;
  logic                   lz_found;
  logic                   slot_free;
  digit_t                 top_digit;

  generate
    if (VALUE_WIDTH <= VALUE_IN_W) begin : g_trunc
      assign val = in_value[VALUE_WIDTH-1:0];
    end else begin : g_sext
      assign val = {{(VALUE_WIDTH-VALUE_IN_W){in_value[VALUE_IN_W-1]}}, in_value};
    end
  endgenerate

  assign val_neg = val[VALUE_WIDTH-1];
  assign val_mag = val_neg ? (~val + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : val;

  sidau_bcd_adjust #(
    .NUM_DIGITS (ND)
  ) u_adjust (
    .bcd_i (bcd_r),
    .bcd_o (bcd_adj)
  );

  // leading zero digits, keeping at least one digit
  always_comb begin
    lz       = '0;
    lz_found = 1'b0;
    for (int i = ND - 1; i >= 1; i--) begin
      if (!lz_found) begin
        if (bcd_r[i*DIGIT_W +: DIGIT_W] != '0) begin
          lz_found = 1'b1;
        end else begin
          lz = lz + NDIG_W'(1);
        end
      end
    end
  end

  assign slot_free = !out_valid_r || !out_stall;
  assign top_digit = bcd_r[BCD_W-1 -: DIGIT_W];

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    bcd_nxt       = bcd_r;
    cnt_nxt       = cnt_r;
    ndig_nxt      = ndig_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mag_nxt   = val_mag;
          neg_nxt   = val_neg;
          bcd_nxt   = '0;
          cnt_nxt   = CNT_W'(VALUE_WIDTH);
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        bcd_nxt = {bcd_adj[BCD_W-2:0], mag_r[VALUE_WIDTH-1]};
        mag_nxt = {mag_r[VALUE_WIDTH-2:0], 1'b0};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = S_ALIGN;
        end
      end
      S_ALIGN: begin
        bcd_nxt   = bcd_r << {lz, 2'b00};
        ndig_nxt  = NDIG_W'(ND) - lz;
        state_nxt = neg_r ? S_SIGN : S_EMIT;
      end
      S_SIGN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHR_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHR_ZERO + {3'b000, top_digit};
          out_last_nxt  = (ndig_r == NDIG_W'(1));
          bcd_nxt       = {bcd_r[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
          ndig_nxt      = ndig_r - NDIG_W'(1);
          if (ndig_r == NDIG_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    bcd_r      <= bcd_nxt;
    cnt_r      <= cnt_nxt;
    ndig_r     <= ndig_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_ascii_char = out_char_r;
  assign out_last_char  = out_last_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_CONV))
    else $error("accepted request did not start conversion");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ascii_char == CHR_MINUS) |-> !out_last_char)
    else $error("minus sign marked as last character");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ascii_char != CHR_MINUS) |->
      (out_ascii_char >= CHR_ZERO && out_ascii_char <= CHR_ZERO + 7'd9))
    else $error("emitted character is not a digit");

  a_emit_has_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (ndig_r != '0))
    else $error("emit state with no digits left");

endmodule
